>>> rtl/sfw_pkg.sv
// Shared types and constants of the 3x3 sharpening filter.
`timescale 1ns / 1ps
`default_nettype none

package sfw_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int CFG_WID_W  = 9;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int MIN_SIZE   = 4;
    localparam int RST_WIDTH  = 256;
    localparam int RST_HEIGHT = 256;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } sfw_reg_t;

    // one window column: [0] top, [1] middle, [2] bottom
    typedef logic [2:0][PIX_W-1:0] sfw_column_t;

    // which border copies an interior result also feeds
    typedef struct packed {
        logic row_lo;
        logic row_hi;
        logic col_lo;
        logic col_hi;
    } sfw_border_t;

endpackage

`default_nettype wire

>>> rtl/sfw_col_cell.sv
// One column cell of the 3x3 window chain.
`timescale 1ns / 1ps
`default_nettype none

module sfw_col_cell
    import sfw_pkg::*;
(
    input  logic        clk,
    input  logic        shift,
    input  sfw_column_t d,
    output sfw_column_t q
);

    sfw_column_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= d;
        end
    end

    assign q = col_reg;

endmodule

`default_nettype wire

>>> rtl/sfw_window.sv
// Line stores, window cell chain and sharpening arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module sfw_window
    import sfw_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int ROW_W     = 12,
    parameter int COL_W     = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [PIX_W-1:0] pixel,
    input  logic [ROW_W-1:0] row,
    input  logic [COL_W-1:0] col,
    input  logic [ROW_W-1:0] h_last,
    input  logic [COL_W-1:0] w_last,
    output logic             push,
    output logic [PIX_W-1:0] push_value,
    output logic [ROW_W-1:0] push_row,
    output logic [COL_W-1:0] push_col,
    output sfw_border_t      push_border,
    output logic [1:0]       inflight
);

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [PIX_W-1:0] top_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;

    logic             s2_valid_reg;
    logic [PIX_W-1:0] s2_value_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic [COL_W-1:0] s2_col_reg;
    sfw_border_t      s2_border_reg;

    sfw_column_t cur_col;
    sfw_column_t new_col;
    sfw_column_t old_col;
    logic        has_result;
    sfw_border_t border;

    function automatic logic [PIX_W-1:0] sharpen(
        input sfw_column_t a,
        input sfw_column_t b,
        input sfw_column_t c
    );
        logic [10:0]        nsum;
        logic [11:0]        gain;
        logic signed [12:0] sum;
        logic [PIX_W-1:0]   res;
        nsum = 11'(a[0]) + 11'(a[1]) + 11'(a[2]) + 11'(b[0]) + 11'(b[2])
             + 11'(c[0]) + 11'(c[1]) + 11'(c[2]);
        gain = 12'({b[1], 3'b000}) + 12'({b[1], 2'b00});
        sum  = $signed({1'b0, gain}) - $signed({2'b00, nsum});
        // negative sums truncate to zero or below, both clamp to zero
        priority if (sum[12])
            res = '0;
        else if (sum[11:2] > 10'd255)
            res = '1;
        else
            res = sum[9:2];
        return res;
    endfunction

    // stage 0: line store read at the accepted column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_rd_reg   <= older_mem[col];
            mid_rd_reg   <= newer_mem[col];
            s1_pixel_reg <= pixel;
            s1_row_reg   <= row;
            s1_col_reg   <= col;
        end
        if (s1_valid_reg)
        begin
            older_mem[s1_col_reg] <= mid_rd_reg;
            newer_mem[s1_col_reg] <= s1_pixel_reg;
        end
    end

    // stage 1: window formed from current column plus two cells
    assign cur_col[0] = top_rd_reg;
    assign cur_col[1] = mid_rd_reg;
    assign cur_col[2] = s1_pixel_reg;

    sfw_col_cell u_cell_new
    (
        .clk   (clk),
        .shift (s1_valid_reg),
        .d     (cur_col),
        .q     (new_col)
    );

    sfw_col_cell u_cell_old
    (
        .clk   (clk),
        .shift (s1_valid_reg),
        .d     (new_col),
        .q     (old_col)
    );

    assign has_result = s1_valid_reg && (s1_row_reg >= ROW_W'(2))
                        && (s1_col_reg >= COL_W'(2));

    always_comb
    begin
        border.row_lo = (s1_row_reg == ROW_W'(2));
        border.row_hi = (s1_row_reg == h_last);
        border.col_lo = (s1_col_reg == COL_W'(2));
        border.col_hi = (s1_col_reg == w_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= has_result;
        end
    end

    // stage 2: registered interior result
    always_ff @(posedge clk)
    begin
        if (has_result)
        begin
            s2_value_reg  <= sharpen(old_col, new_col, cur_col);
            s2_row_reg    <= s1_row_reg - ROW_W'(1);
            s2_col_reg    <= s1_col_reg - COL_W'(1);
            s2_border_reg <= border;
        end
    end

    assign push        = s2_valid_reg;
    assign push_value  = s2_value_reg;
    assign push_row    = s2_row_reg;
    assign push_col    = s2_col_reg;
    assign push_border = s2_border_reg;
    assign inflight    = 2'(s1_valid_reg) + 2'(s2_valid_reg);

endmodule

`default_nettype wire

>>> rtl/sfw_expander.sv
// Result queue and border fan-out onto the output register.
`timescale 1ns / 1ps
`default_nettype none

module sfw_expander
    import sfw_pkg::*;
#(
    parameter int ROW_W = 12,
    parameter int COL_W = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [PIX_W-1:0]   push_value,
    input  logic [ROW_W-1:0]   push_row,
    input  logic [COL_W-1:0]   push_col,
    input  sfw_border_t        push_border,
    input  logic [ROW_W-1:0]   h_last,
    input  logic [COL_W-1:0]   w_last,
    output logic [Q_LVL_W-1:0] level,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [ROW_W-1:0]   out_row,
    output logic [COL_W-1:0]   out_col,
    output logic [PIX_W-1:0]   out_value,
    output logic               out_last
);

    logic [PIX_W-1:0] q_value_reg  [Q_DEPTH];
    logic [ROW_W-1:0] q_row_reg    [Q_DEPTH];
    logic [COL_W-1:0] q_col_reg    [Q_DEPTH];
    sfw_border_t      q_border_reg [Q_DEPTH];

    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_LVL_W-1:0] level_reg, level_next;
    logic [1:0]         row_idx_reg, row_idx_next;
    logic [1:0]         col_idx_reg, col_idx_next;

    logic             out_valid_reg, out_valid_next;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [PIX_W-1:0] out_value_reg;
    logic             out_last_reg;

    sfw_border_t      hb;
    logic             head_valid;
    logic             emit;
    logic             pop;
    logic             row_done;
    logic             col_done;
    logic [ROW_W-1:0] row_sel;
    logic [COL_W-1:0] col_sel;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_value_reg[wr_ptr_reg]  <= push_value;
            q_row_reg[wr_ptr_reg]    <= push_row;
            q_col_reg[wr_ptr_reg]    <= push_col;
            q_border_reg[wr_ptr_reg] <= push_border;
        end
    end

    assign hb         = q_border_reg[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign emit       = head_valid && (!out_valid_reg || out_ready);
    assign row_done   = (row_idx_reg == 2'(hb.row_lo) + 2'(hb.row_hi));
    assign col_done   = (col_idx_reg == 2'(hb.col_lo) + 2'(hb.col_hi));
    assign pop        = emit && row_done && col_done;

    // position lists: [0 if low edge], interior, [last if high edge]
    always_comb
    begin
        priority if (hb.row_lo && row_idx_reg == 2'd0)
            row_sel = '0;
        else if (row_idx_reg == 2'(hb.row_lo))
            row_sel = q_row_reg[rd_ptr_reg];
        else
            row_sel = h_last;

        priority if (hb.col_lo && col_idx_reg == 2'd0)
            col_sel = '0;
        else if (col_idx_reg == 2'(hb.col_lo))
            col_sel = q_col_reg[rd_ptr_reg];
        else
            col_sel = w_last;
    end

    always_comb
    begin
        wr_ptr_next    = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next    = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        level_next     = level_reg + Q_LVL_W'(push) - Q_LVL_W'(pop);
        row_idx_next   = row_idx_reg;
        col_idx_next   = col_idx_reg;
        if (emit)
        begin
            if (col_done)
            begin
                col_idx_next = '0;
                row_idx_next = row_done ? 2'd0 : row_idx_reg + 2'd1;
            end
            else
            begin
                col_idx_next = col_idx_reg + 2'd1;
            end
        end
        out_valid_next = emit || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            level_reg     <= '0;
            row_idx_reg   <= '0;
            col_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            level_reg     <= level_next;
            row_idx_reg   <= row_idx_next;
            col_idx_reg   <= col_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg   <= row_sel;
            out_col_reg   <= col_sel;
            out_value_reg <= q_value_reg[rd_ptr_reg];
            out_last_reg  <= hb.row_hi && hb.col_hi && row_done && col_done;
        end
    end

    assign level     = level_reg;
    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg != Q_LVL_W'(Q_DEPTH)))
        else $error("result queue overflow");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= Q_LVL_W'(Q_DEPTH))
        else $error("result queue level out of range");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (row_idx_reg == 2'd0 && col_idx_reg == 2'd0))
        else $error("fan-out index not cleared with empty queue");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (row_idx_reg <= 2'(hb.row_lo) + 2'(hb.row_hi)))
        else $error("row fan-out index past list end");
`endif

endmodule

`default_nettype wire

>>> rtl/sharpening_3x3_window_filter.sv
// Top level of the streaming 3x3 Laplacian high-boost sharpening filter.
// Takes one grey pixel per clock in raster order while s_axis_tready is high;
// row and column are counted internally and restart at the origin on any
// register write. Each pixel at row>=2, col>=2 yields one interior result
// (12*centre - 8 neighbors)/4, clamped to 0..255, for the window centred one
// row up and one column left; border positions repeat the nearest interior
// result, so one pixel gives one to four results. Results leave one per clock
// while m_axis_tready is high: in interior rows the input stalls where the
// extra left-border result uses up the four credits shared by the result
// queue and the two pipeline stages; pixels of the first and last interior
// result rows and the four corner pixels stall the input longer, as set by
// the single output register behind a four-entry result queue. The first
// result of a pixel passes the stage-1 and stage-2 registers, the result
// queue and the output register. Line stores need no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module sharpening_3x3_window_filter
    import sfw_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int ROW_W     = $clog2(MAX_HEIGHT),
    localparam int OUT_DW    = ((ROW_W + COL_W + PIX_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // pixel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DW-1:0]     m_axis_tdata,   // out_row, out_col, sharpened
    output logic                  m_axis_tlast    // frame_end
);

    logic [CFG_WID_W-1:0] width_reg, width_next;
    logic [CFG_HGT_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;

    logic [COL_W-1:0]   w_last;
    logic [ROW_W-1:0]   h_last;
    logic               accept;
    logic [1:0]         inflight;
    logic [Q_LVL_W-1:0] level;

    logic               push;
    logic [PIX_W-1:0]   push_value;
    logic [ROW_W-1:0]   push_row;
    logic [COL_W-1:0]   push_col;
    sfw_border_t        push_border;

    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic [PIX_W-1:0]   out_value;

    // effective frame size, clamped to MIN_SIZE..MAX
    always_comb
    begin
        priority if (width_reg < MIN_SIZE)
            w_last = COL_W'(MIN_SIZE - 1);
        else if (width_reg > MAX_WIDTH)
            w_last = COL_W'(MAX_WIDTH - 1);
        else
            w_last = COL_W'(width_reg - CFG_WID_W'(1));

        priority if (height_reg < MIN_SIZE)
            h_last = ROW_W'(MIN_SIZE - 1);
        else if (height_reg > MAX_HEIGHT)
            h_last = ROW_W'(MAX_HEIGHT - 1);
        else
            h_last = ROW_W'(height_reg - CFG_HGT_W'(1));
    end

    assign s_axis_tready = (int'(level) + int'(inflight)) < Q_DEPTH;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        priority if (cfg_we)
        begin
            unique case (sfw_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = cfg_data[CFG_WID_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[CFG_HGT_W-1:0];
                default:          width_next  = width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_WID_W'(RST_WIDTH);
            height_reg <= CFG_HGT_W'(RST_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    sfw_window
    #(
        .MAX_WIDTH (MAX_WIDTH),
        .ROW_W     (ROW_W),
        .COL_W     (COL_W)
    )
    u_window
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel       (s_axis_tdata),
        .row         (row_reg),
        .col         (col_reg),
        .h_last      (h_last),
        .w_last      (w_last),
        .push        (push),
        .push_value  (push_value),
        .push_row    (push_row),
        .push_col    (push_col),
        .push_border (push_border),
        .inflight    (inflight)
    );

    sfw_expander
    #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    )
    u_expander
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_value  (push_value),
        .push_row    (push_row),
        .push_col    (push_col),
        .push_border (push_border),
        .h_last      (h_last),
        .w_last      (w_last),
        .level       (level),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_row     (out_row),
        .out_col     (out_col),
        .out_value   (out_value),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_DW'({out_value, out_col, out_row});

endmodule

`default_nettype wire
